@@ hdl/dva_pkg.sv @@
// Package: request/response types, sequencer states and calendar helpers for the date adder.
package dva_pkg;

  localparam logic [3:0]  MonthJan     = 4'd1;
  localparam logic [3:0]  MonthFeb     = 4'd2;
  localparam logic [3:0]  MonthApr     = 4'd4;
  localparam logic [3:0]  MonthJun     = 4'd6;
  localparam logic [3:0]  MonthSep     = 4'd9;
  localparam logic [3:0]  MonthNov     = 4'd11;
  localparam logic [3:0]  MonthDec     = 4'd12;
  localparam logic [13:0] GregCycle    = 14'd400;
  localparam logic [8:0]  CycleLast    = 9'd399;
  localparam logic [8:0]  Century1     = 9'd100;
  localparam logic [8:0]  Century2     = 9'd200;
  localparam logic [8:0]  Century3     = 9'd300;

  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [15:0] add_days;
  } dva_req_t;

  typedef struct packed {
    logic        date_ok;
    logic [4:0]  end_day;
    logic [3:0]  end_month;
    logic [13:0] end_year;
  } dva_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } dva_state_e;

  // Days in month m; leap selects 29-day February.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      MonthFeb: len = leap ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ hdl/date_validate_and_add_days_core.sv @@
// Top level: Gregorian date check and day-count adder with a shared subtractor.
//
// Usage:
//   Request channel: drive req_i and pulse start while busy is low; the
//   request is taken on that clock edge and busy rises on the next cycle.
//   Response channel: rsp_o is presented for exactly one cycle with
//   result_valid_o high. The receiver cannot stall; it must take it then.
// Sequence: the year is reduced mod 400 by repeated subtraction, the start
//   date is checked, and the day count is stepped forward a month at a
//   time until it lands inside a month; the number of passes grows with
//   start_year and the number of month steps with the day count. One
//   request is in flight at a time. Both phases run through the same
//   16-bit subtractor/comparator.
// Invalid dates (day 0, month outside 1..12, day past month end) skip the
//   month stepping and echo the request fields with date_ok = 0.
// Years roll over modulo 16384 in end_year; the leap rule keeps using the
//   exact year because it is tracked as year mod 400 alongside.
// Reset: rst_ni is asynchronous, active low; the sequencer returns to idle,
//   busy drops and no strobe is issued.
module date_validate_and_add_days_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dva_pkg::dva_req_t req_i,
  output logic              result_valid_o,
  output dva_pkg::dva_rsp_t rsp_o
);
  import dva_pkg::*;

  dva_state_e  state_q, state_d;
  logic [4:0]  day_q;
  logic [3:0]  mon_q;
  logic [13:0] year_q;
  logic [15:0] rem_q;
  logic [13:0] r_q;       // year during reduction, then year mod 400
  logic        ok_q;

  // Calendar view of the current date
  logic        leap;
  logic [4:0]  mlen;
  logic [5:0]  to_next;
  logic        date_ok;

  // Shared subtractor
  logic        sel_mod;
  logic [15:0] op_a, op_b;
  logic [16:0] diff;
  logic        borrow;

  assign leap = (year_q[1:0] == 2'b00) &&
                (r_q[8:0] != Century1) && (r_q[8:0] != Century2) &&
                (r_q[8:0] != Century3);
  assign mlen    = month_len(mon_q, leap);
  assign to_next = {1'b0, mlen} - {1'b0, day_q} + 6'd1;
  assign date_ok = (day_q != 5'd0) && (mon_q >= MonthJan) && (mon_q <= MonthDec) &&
                   (day_q <= mlen);

  assign op_a   = sel_mod ? {2'b00, r_q} : rem_q;
  assign op_b   = sel_mod ? {2'b00, GregCycle} : {10'd0, to_next};
  assign diff   = {1'b0, op_a} - {1'b0, op_b};
  assign borrow = diff[16];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_MOD;
      ST_MOD:   if (borrow) state_d = ST_CHECK;
      ST_CHECK: state_d = (date_ok && (rem_q != 16'd0)) ? ST_STEP : ST_DONE;
      ST_STEP:  if (borrow || (diff[15:0] == 16'd0)) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy           = 1'b1;
    result_valid_o = 1'b0;
    sel_mod        = 1'b0;
    unique case (state_q)
      ST_IDLE:  busy = 1'b0;
      ST_MOD:   sel_mod = 1'b1;
      ST_CHECK: ;
      ST_STEP:  ;
      ST_DONE:  result_valid_o = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          day_q  <= req_i.start_day;
          mon_q  <= req_i.start_month;
          year_q <= req_i.start_year;
          rem_q  <= req_i.add_days;
          r_q    <= req_i.start_year;
        end
      end
      ST_MOD: begin
        if (!borrow) r_q <= diff[13:0];
      end
      ST_CHECK: ok_q <= date_ok;
      ST_STEP: begin
        if (borrow) begin
          // remaining days land inside this month
          day_q <= day_q + rem_q[4:0];
          rem_q <= 16'd0;
        end else begin
          rem_q <= diff[15:0];
          day_q <= 5'd1;
          if (mon_q == MonthDec) begin
            mon_q  <= MonthJan;
            year_q <= year_q + 14'd1;
            r_q    <= (r_q[8:0] == CycleLast) ? 14'd0 : r_q + 14'd1;
          end else begin
            mon_q <= mon_q + 4'd1;
          end
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign rsp_o.date_ok   = ok_q;
  assign rsp_o.end_day   = day_q;
  assign rsp_o.end_month = mon_q;
  assign rsp_o.end_year  = year_q;

  // Assertions
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_strobe_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy)
    else $error("busy held after result strobe");

  a_step_mod400: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (r_q < GregCycle))
    else $error("year residue out of range while stepping");

  a_ok_date_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.date_ok |->
      (rsp_o.end_day != 5'd0) && (rsp_o.end_month >= MonthJan) &&
      (rsp_o.end_month <= MonthDec))
    else $error("valid result carries impossible date");

endmodule

@@ tb/date_validate_and_add_days_core_tb.sv @@
// Testbench for the Gregorian date check and day-count adder core.
`timescale 1ns / 100ps

module date_validate_and_add_days_core_tb;
  import dva_pkg::*;

  // Covers the worst-case latency for each of 259 requests with gaps,
  // taken four times over.
  localparam int unsigned CycleLimit = 2_500_000;
  // Cycles to let pass after the last result before closing the run.
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned MaxReported = 10;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  dva_req_t req_i;
  logic     result_valid_o;
  dva_rsp_t rsp_o;

  // Predicted end dates, oldest first.
  dva_rsp_t    expected_dates[$];
  int unsigned fail_count;
  int unsigned cycle_count;

  date_validate_and_add_days_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Divisible by 4 and not by 100, or divisible by 400.
  function automatic bit year_is_leap(input int unsigned year);
    return ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned month,
                                                input int unsigned year);
    int unsigned len;
    case (month)
      MonthFeb: len = year_is_leap(year) ? 29 : 28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  // Validate the start date and step it forward month by month. The year is
  // kept exact here and only cut to 14 bits on the way out.
  function automatic dva_rsp_t advance_date(input dva_req_t r);
    dva_rsp_t    res;
    int unsigned day;
    int unsigned month;
    int unsigned year;
    int unsigned left;
    int unsigned span;
    bit          ok;
    day   = r.start_day;
    month = r.start_month;
    year  = r.start_year;
    left  = r.add_days;
    ok = (day >= 1) && (month >= MonthJan) && (month <= MonthDec) &&
         (day <= days_in_month(month, year));
    if (ok) begin
      while (left > 0) begin
        span = days_in_month(month, year) - day + 1;
        if (left < span) begin
          day  = day + left;
          left = 0;
        end else begin
          left  = left - span;
          day   = 1;
          month = month + 1;
          if (month > MonthDec) begin
            month = MonthJan;
            year  = year + 1;
          end
        end
      end
    end
    res.date_ok   = ok;
    res.end_day   = day[4:0];
    res.end_month = month[3:0];
    res.end_year  = year[13:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReported) $display("%s", msg);
  endfunction

  // Present one request and hold it until the core takes it. Start is left
  // high on return so a following request can go out without a gap.
  task automatic send_request(input dva_req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    expected_dates.push_back(advance_date(r));
  endtask

  task automatic send_date(input int unsigned day, input int unsigned month,
                           input int unsigned year, input int unsigned count);
    dva_req_t r;
    r.start_day   = day[4:0];
    r.start_month = month[3:0];
    r.start_year  = year[13:0];
    r.add_days    = count[15:0];
    send_request(r);
  endtask

  // Random idle burst after an accepted request; lands on any phase of the
  // core's work since latency varies with year and day count.
  task automatic sender_pause();
    if ($urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Mostly small day counts keep the run short; a few span the full range.
  function automatic int unsigned pick_day_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(0, 400);
    if (sel < 90) return $urandom_range(401, 4000);
    return $urandom_range(0, 65535);
  endfunction

  function automatic int unsigned pick_year();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       return $urandom_range(10000, 16383);       // past the nominal range
      1, 2:    return 100 * $urandom_range(0, 99) + $urandom_range(0, 3); // centuries
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  // Well-formed date with random content, or raw noise on every field.
  function automatic dva_req_t make_request();
    dva_req_t    r;
    int unsigned month;
    int unsigned year;
    logic [63:0] noise;
    if ($urandom_range(0, 4) == 0) begin
      noise = {$urandom, $urandom};
      r     = noise[$bits(dva_req_t)-1:0];
    end else begin
      year          = pick_year();
      month         = $urandom_range(MonthJan, MonthDec);
      r.start_year  = year[13:0];
      r.start_month = month[3:0];
      r.start_day   = 5'($urandom_range(1, days_in_month(month, year)));
      r.add_days    = 16'(pick_day_count());
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_invalid_dates();
    send_date(0, 5, 2020, 10);          // day zero
    send_date(15, 0, 2020, 3);          // month zero
    send_date(15, 13, 2020, 3);         // month past December
    send_date(31, 15, 16383, 65535);    // every input bit set
    send_date(0, 0, 0, 0);              // every input bit clear
    send_date(31, 4, 2021, 1);          // past end of a 30-day month
    send_date(29, 2, 1900, 1);          // century that is not a leap year
    sender_pause();
  endtask

  task automatic test_leap_years();
    send_date(29, 2, 2000, 1);          // every 400 years is leap
    send_date(29, 2, 2024, 365);
    send_date(28, 2, 2100, 1);          // skips Feb 29
    send_date(28, 2, 1899, 36525);      // across a non-leap century
    send_date(1, 1, 0, 0);              // year zero, no day count
    send_date(1, 3, 0, 0);
    send_date(30, 4, 2021, 1);
    sender_pause();
  endtask

  task automatic test_rollover();
    send_date(31, 12, 9999, 1);         // into the five-digit years
    send_date(31, 8, 2023, 31);
    send_date(1, 1, 16383, 65535);      // year wraps in 14 bits
    send_date(31, 1, 0, 65535);
    send_date(31, 12, 16383, 1);        // wraps straight to year 0
    sender_pause();
  endtask

  task automatic test_random_traffic();
    repeat (200) begin
      send_request(make_request());
      sender_pause();
    end
  endtask

  // Closing stretch: start never drops between requests.
  task automatic test_back_to_back();
    repeat (40) send_request(make_request());
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    dva_rsp_t exp_rsp;
    if (rst_ni && result_valid_o) begin
      if (expected_dates.size() == 0) begin
        note_failure($sformatf("unexpected result ok=%0b %0d/%0d/%0d", rsp_o.date_ok,
                               rsp_o.end_day, rsp_o.end_month, rsp_o.end_year));
      end else begin
        exp_rsp = expected_dates.pop_front();
        if (rsp_o.date_ok !== exp_rsp.date_ok || rsp_o.end_day !== exp_rsp.end_day ||
            rsp_o.end_month !== exp_rsp.end_month ||
            rsp_o.end_year !== exp_rsp.end_year) begin
          note_failure($sformatf("mismatch: exp ok=%0b %0d/%0d/%0d got ok=%0b %0d/%0d/%0d",
                                 exp_rsp.date_ok, exp_rsp.end_day, exp_rsp.end_month,
                                 exp_rsp.end_year, rsp_o.date_ok, rsp_o.end_day,
                                 rsp_o.end_month, rsp_o.end_year));
        end
      end
    end
  end

  // Watchdog on total cycles.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL date_validate_and_add_days_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    fail_count = 0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_invalid_dates();
    test_leap_years();
    test_rollover();
    test_random_traffic();
    test_back_to_back();
    start <= 1'b0;

    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS date_validate_and_add_days_core");
    end else begin
      $display("FAIL date_validate_and_add_days_core");
    end
    $finish;
  end

endmodule

@@ date_validate_and_add_days_core.f @@
hdl/dva_pkg.sv
hdl/date_validate_and_add_days_core.sv
tb/date_validate_and_add_days_core_tb.sv
